@@ src/shie_pkg.sv @@
// ----------------------------------------------------------------------------
// shie_pkg: shared types, constants and helpers for the SH irradiance evaluator
// Holds the fixed-point lobe and basis constants, the register map, the
// payload structs passed between pipeline stages and the coefficient decode.
// ----------------------------------------------------------------------------
package shie_pkg;

  // Coefficient field width inside each 16-bit slot; values above 16 act as 16.
  localparam int COEF_WIDTH = 16;
  localparam int COEF_SLOT  = 16;
  localparam int COEF_W     = (COEF_WIDTH > COEF_SLOT) ? COEF_SLOT : COEF_WIDTH;
  localparam int NUM_COEF   = 9;

  // Configuration register map.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEF_LOW  = CFG_ADDR_W'(0),
    REG_COEF_MID  = CFG_ADDR_W'(1),
    REG_COEF_LAST = CFG_ADDR_W'(2),
    REG_EVAL_MODE = CFG_ADDR_W'(3)
  } cfg_reg_e;

  typedef enum logic {
    MODE_IRRADIANCE = 1'b0,
    MODE_RADIANCE   = 1'b1
  } eval_mode_e;

  // Datapath widths.
  localparam int DIR_W      = 16;               // Q1.14 direction component
  localparam int KW         = 18;               // Q16 constant, positive, signed
  localparam int PROD_SHIFT = 8;                // Q28 -> Q20 product rounding
  localparam int PW         = 2*DIR_W - PROD_SHIFT;  // rounded Q20 product
  localparam int LIN_SHIFT  = 6;                // Q14 -> Q20 for linear terms
  localparam int LW         = DIR_W + LIN_SHIFT;
  localparam int BW         = PW + 1;           // difference of two products
  localparam int ONE_SHIFT  = 20;               // constant 1.0 in Q20
  localparam int WK_W       = COEF_SLOT + KW;   // constant times coefficient
  localparam int TERM_W     = 60;               // Q46 term and sum
  localparam int NUM_TERMS  = 10;
  localparam int RND_SHIFT  = 30;               // Q46 -> Q16
  localparam int RES_W      = TERM_W - RND_SHIFT;
  localparam int OUT_W      = 32;

  localparam longint SAT_MAX = (64'sd1 <<< (OUT_W-1)) - 64'sd1;
  localparam longint SAT_MIN = -(64'sd1 <<< (OUT_W-1));

  // Q16 constants, rounded to nearest.
  localparam logic signed [KW-1:0] K_C1    = KW'(28118);
  localparam logic signed [KW-1:0] K_2C1   = KW'(56236);
  localparam logic signed [KW-1:0] K_2C2   = KW'(67065);
  localparam logic signed [KW-1:0] K_C3    = KW'(48701);
  localparam logic signed [KW-1:0] K_C4    = KW'(58080);
  localparam logic signed [KW-1:0] K_C5    = KW'(16234);
  localparam logic signed [KW-1:0] K_Y0    = KW'(18487);
  localparam logic signed [KW-1:0] K_Y1    = KW'(32021);
  localparam logic signed [KW-1:0] K_Y2    = KW'(71601);
  localparam logic signed [KW-1:0] K_Y20   = KW'(20670);
  localparam logic signed [KW-1:0] K_Y20X3 = KW'(3 * 20670);
  localparam logic signed [KW-1:0] K_Y22   = KW'(35801);

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
  } dir_t;

  typedef struct packed {
    eval_mode_e                              mode;
    logic [NUM_COEF-1:0][COEF_SLOT-1:0]      coef;
  } cfg_t;

  // Stage 1 result: constant-weighted coefficients and direction products.
  typedef struct packed {
    logic [NUM_COEF-1:0][WK_W-1:0] wk;
    logic signed [WK_W-1:0]        wk6c;   // constant part of the zonal term
    logic signed [PW-1:0]          xx;
    logic signed [PW-1:0]          yy;
    logic signed [PW-1:0]          zz;
    logic signed [PW-1:0]          xy;
    logic signed [PW-1:0]          xz;
    logic signed [PW-1:0]          yz;
    logic signed [DIR_W-1:0]       x;
    logic signed [DIR_W-1:0]       y;
    logic signed [DIR_W-1:0]       z;
  } basis_t;

  typedef logic [NUM_TERMS-1:0][TERM_W-1:0] term_set_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    sat;
  } shade_t;

  // Low COEF_W bits of a slot, sign-extended back to the slot width.
  function automatic logic signed [COEF_SLOT-1:0] coef_from_slot(
    input logic [COEF_SLOT-1:0] slot
  );
    logic signed [COEF_SLOT-1:0] up;
    up = signed'(slot << (COEF_SLOT - COEF_W));
    return up >>> (COEF_SLOT - COEF_W);
  endfunction

endpackage

@@ src/shie_dir_if.sv @@
// ----------------------------------------------------------------------------
// shie_dir_if: direction item channel
// Valid/ready channel carrying one Q1.14 direction per item.
// ----------------------------------------------------------------------------
interface shie_dir_if;
  import shie_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;

  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

@@ src/shie_shade_if.sv @@
// ----------------------------------------------------------------------------
// shie_shade_if: result item channel
// Valid/ready channel carrying one saturated Q15.16 shade value per item.
// ----------------------------------------------------------------------------
interface shie_shade_if;
  import shie_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] shade_value;
  logic                    saturated;

  modport source (output valid, shade_value, saturated, input ready);
  modport sink   (input valid, shade_value, saturated, output ready);
endinterface

@@ src/shie_cfg_if.sv @@
// ----------------------------------------------------------------------------
// shie_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface shie_cfg_if;
  import shie_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ src/shie_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// shie_cfg_regs: configuration register file
// Holds the nine coefficients and the evaluation mode, and presents the
// coefficients decoded to the configured width.
// ----------------------------------------------------------------------------
module shie_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  shie_cfg_if.sink       cfg,
  output shie_pkg::cfg_t settings
);
  import shie_pkg::*;

  logic [CFG_DATA_W-1:0] coef_low;
  logic [CFG_DATA_W-1:0] coef_mid;
  logic [COEF_SLOT-1:0]  coef_last;
  eval_mode_e            mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_low  <= '0;
      coef_mid  <= '0;
      coef_last <= '0;
      mode      <= MODE_IRRADIANCE;
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.addr))
        REG_COEF_LOW:  coef_low  <= cfg.data;
        REG_COEF_MID:  coef_mid  <= cfg.data;
        REG_COEF_LAST: coef_last <= cfg.data[COEF_SLOT-1:0];
        REG_EVAL_MODE: mode      <= eval_mode_e'(cfg.data[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    settings.mode = mode;
    for (int k = 0; k < 4; k++) begin
      settings.coef[k]     = coef_from_slot(coef_low[COEF_SLOT*k +: COEF_SLOT]);
      settings.coef[k + 4] = coef_from_slot(coef_mid[COEF_SLOT*k +: COEF_SLOT]);
    end
    settings.coef[8] = coef_from_slot(coef_last);
  end

endmodule

@@ src/shie_basis.sv @@
// ----------------------------------------------------------------------------
// shie_basis: first pipeline stage
// Forms the rounded Q20 direction products and multiplies each coefficient by
// the constant that the selected mode applies to it.
// ----------------------------------------------------------------------------
module shie_basis (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  shie_pkg::dir_t   in_dir,
  input  shie_pkg::cfg_t   settings,
  output logic             out_valid,
  input  logic             out_ready,
  output shie_pkg::basis_t out_basis
);
  import shie_pkg::*;

  localparam logic [2*DIR_W-1:0] HALF_LSB = (2*DIR_W)'(1) << (PROD_SHIFT - 1);

  logic signed [KW-1:0]        kc   [NUM_COEF];
  logic signed [KW-1:0]        k6c;
  logic signed [2*DIR_W-1:0]   pxx, pyy, pzz, pxy, pxz, pyz;
  logic        [2*DIR_W-1:0]   rxx, ryy, rzz, rxy, rxz, ryz;
  basis_t                      basis_next;
  logic                        valid;
  basis_t                      basis;

  // Mode picks the lobe-weighted irradiance constants or the plain basis ones.
  always_comb begin
    if (settings.mode == MODE_RADIANCE) begin
      kc[0] = K_Y0;
      kc[1] = K_Y1;  kc[2] = K_Y1;  kc[3] = K_Y1;
      kc[4] = K_Y2;  kc[5] = K_Y2;  kc[7] = K_Y2;
      kc[6] = K_Y20X3;
      kc[8] = K_Y22;
      k6c   = K_Y20;
    end else begin
      kc[0] = K_C4;
      kc[1] = K_2C2; kc[2] = K_2C2; kc[3] = K_2C2;
      kc[4] = K_2C1; kc[5] = K_2C1; kc[7] = K_2C1;
      kc[6] = K_C3;
      kc[8] = K_C1;
      k6c   = K_C5;
    end
  end

  assign pxx = in_dir.x * in_dir.x;
  assign pyy = in_dir.y * in_dir.y;
  assign pzz = in_dir.z * in_dir.z;
  assign pxy = in_dir.x * in_dir.y;
  assign pxz = in_dir.x * in_dir.z;
  assign pyz = in_dir.y * in_dir.z;

  // Round half up, then floor shift to Q20.
  assign rxx = pxx + HALF_LSB;
  assign ryy = pyy + HALF_LSB;
  assign rzz = pzz + HALF_LSB;
  assign rxy = pxy + HALF_LSB;
  assign rxz = pxz + HALF_LSB;
  assign ryz = pyz + HALF_LSB;

  always_comb begin
    for (int k = 0; k < NUM_COEF; k++) begin
      basis_next.wk[k] = WK_W'(signed'(settings.coef[k]) * kc[k]);
    end
    basis_next.wk6c = WK_W'(signed'(settings.coef[6]) * k6c);
    basis_next.xx   = rxx[2*DIR_W-1:PROD_SHIFT];
    basis_next.yy   = ryy[2*DIR_W-1:PROD_SHIFT];
    basis_next.zz   = rzz[2*DIR_W-1:PROD_SHIFT];
    basis_next.xy   = rxy[2*DIR_W-1:PROD_SHIFT];
    basis_next.xz   = rxz[2*DIR_W-1:PROD_SHIFT];
    basis_next.yz   = ryz[2*DIR_W-1:PROD_SHIFT];
    basis_next.x    = in_dir.x;
    basis_next.y    = in_dir.y;
    basis_next.z    = in_dir.z;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      basis <= basis_next;
    end
  end

  assign out_valid = valid;
  assign out_basis = basis;

endmodule

@@ src/shie_terms.sv @@
// ----------------------------------------------------------------------------
// shie_terms: second pipeline stage
// Multiplies each weighted coefficient by its basis value, giving ten Q46
// terms; the zonal coefficient contributes a product term and a constant term.
// ----------------------------------------------------------------------------
module shie_terms (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  shie_pkg::basis_t    in_basis,
  output logic                out_valid,
  input  logic                out_ready,
  output shie_pkg::term_set_t out_terms
);
  import shie_pkg::*;

  logic signed [LW-1:0]     x64, y64, z64;
  logic signed [BW-1:0]     dxy;
  logic signed [TERM_W-1:0] t [NUM_TERMS];
  term_set_t                terms_next;
  logic                     valid;
  term_set_t                terms;

  assign x64 = signed'({in_basis.x, {LIN_SHIFT{1'b0}}});
  assign y64 = signed'({in_basis.y, {LIN_SHIFT{1'b0}}});
  assign z64 = signed'({in_basis.z, {LIN_SHIFT{1'b0}}});
  assign dxy = BW'(in_basis.xx) - BW'(in_basis.yy);

  always_comb begin
    t[0] = TERM_W'(signed'(in_basis.wk[0])) <<< ONE_SHIFT;
    t[1] = signed'(in_basis.wk[1]) * y64;
    t[2] = signed'(in_basis.wk[2]) * z64;
    t[3] = signed'(in_basis.wk[3]) * x64;
    t[4] = signed'(in_basis.wk[4]) * in_basis.xy;
    t[5] = signed'(in_basis.wk[5]) * in_basis.yz;
    t[6] = signed'(in_basis.wk[6]) * in_basis.zz;
    t[7] = signed'(in_basis.wk[7]) * in_basis.xz;
    t[8] = signed'(in_basis.wk[8]) * dxy;
    t[9] = -(TERM_W'(in_basis.wk6c) <<< ONE_SHIFT);
    for (int k = 0; k < NUM_TERMS; k++) begin
      terms_next[k] = t[k];
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      terms <= terms_next;
    end
  end

  assign out_valid = valid;
  assign out_terms = terms;

endmodule

@@ src/shie_sum.sv @@
// ----------------------------------------------------------------------------
// shie_sum: adder tree, rounding and saturation
// Three register stages: pairwise sums, two partial sums, then the final add
// with round half up to Q16 and clipping to 32 bits into the output register.
// ----------------------------------------------------------------------------
module shie_sum (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  shie_pkg::term_set_t in_terms,
  output logic                out_valid,
  input  logic                out_ready,
  output shie_pkg::shade_t    out_shade
);
  import shie_pkg::*;

  localparam int NUM_PAIRS = NUM_TERMS / 2;
  localparam logic signed [TERM_W-1:0] RND_HALF = TERM_W'(1) <<< (RND_SHIFT - 1);

  logic                     v3, v4, v5;
  logic                     rdy3, rdy4, rdy5;
  logic signed [TERM_W-1:0] pair [NUM_PAIRS];
  logic signed [TERM_W-1:0] part0, part1;
  logic signed [TERM_W-1:0] total;
  logic signed [RES_W-1:0]  res;
  shade_t                   shade_next;
  shade_t                   shade;

  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign in_ready = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy3) v3 <= in_valid;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
        pair[k] <= signed'(in_terms[2*k]) + signed'(in_terms[2*k + 1]);
      end
    end
    if (rdy4 && v3) begin
      part0 <= pair[0] + pair[1] + pair[2];
      part1 <= pair[3] + pair[4];
    end
    if (rdy5 && v4) begin
      shade <= shade_next;
    end
  end

  assign total = part0 + part1 + RND_HALF;
  assign res   = total[TERM_W-1:RND_SHIFT];

  always_comb begin
    if (longint'(res) > SAT_MAX) begin
      shade_next.value = OUT_W'(SAT_MAX);
      shade_next.sat   = 1'b1;
    end else if (longint'(res) < SAT_MIN) begin
      shade_next.value = OUT_W'(SAT_MIN);
      shade_next.sat   = 1'b1;
    end else begin
      shade_next.value = OUT_W'(res);
      shade_next.sat   = 1'b0;
    end
  end

  assign out_valid = v5;
  assign out_shade = shade;

endmodule

@@ src/sh_irradiance_eval.sv @@
// ----------------------------------------------------------------------------
// sh_irradiance_eval: second-order spherical harmonic irradiance evaluator
// Throughput: one item per cycle while the result channel is ready, set by five fully pipelined register stages.
// Reset (rst, synchronous): empties the pipeline and clears every coefficient
// and the mode to zero, which selects the irradiance formula.
// ----------------------------------------------------------------------------
//
// Each direction item is evaluated against nine signed Q5.10 coefficients.
// Mode 0 applies the irradiance formula with the cosine-lobe constants folded
// in; mode 1 takes the plain radiance basis dot product. Both modes share one
// datapath: every coefficient is first scaled by the Q16 constant its mode
// assigns it, and then by a basis value that does not depend on the mode.
//
// Pipeline:
//   Stage 1 (shie_basis)  direction products rounded to Q20, and coefficient
//                         times constant for all nine coefficients.
//   Stage 2 (shie_terms)  ten Q46 terms; the zonal coefficient gives a term
//                         on z squared and a constant term that is subtracted.
//   Stage 3-5 (shie_sum)  adder tree, round half up to Q16, clip to 32 bits.
//
// Each stage holds a valid bit and loads when it is empty or when the stage
// after it moves on, so bubbles close up and a stalled output does not stop
// new items entering until all five stages hold an item. The output register
// of the last stage drives the result channel directly.
//
// Configuration writes land in shie_cfg_regs. They are meant to happen only
// while no item is in flight; shie_basis reads the registers as items pass.
// ----------------------------------------------------------------------------
module sh_irradiance_eval (
  input  logic          clk,
  input  logic          rst,
  shie_dir_if.sink      dir,
  shie_shade_if.source  shade,
  shie_cfg_if.sink      cfg
);
  import shie_pkg::*;

  cfg_t      settings;
  dir_t      in_dir;
  basis_t    basis;
  term_set_t terms;
  shade_t    result;
  logic      basis_valid, basis_ready;
  logic      terms_valid, terms_ready;

  shie_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  assign in_dir.x = dir.dir_x;
  assign in_dir.y = dir.dir_y;
  assign in_dir.z = dir.dir_z;

  shie_basis u_basis (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dir.valid),
    .in_ready  (dir.ready),
    .in_dir    (in_dir),
    .settings  (settings),
    .out_valid (basis_valid),
    .out_ready (basis_ready),
    .out_basis (basis)
  );

  shie_terms u_terms (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (basis_valid),
    .in_ready  (basis_ready),
    .in_basis  (basis),
    .out_valid (terms_valid),
    .out_ready (terms_ready),
    .out_terms (terms)
  );

  shie_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (terms_valid),
    .in_ready  (terms_ready),
    .in_terms  (terms),
    .out_valid (shade.valid),
    .out_ready (shade.ready),
    .out_shade (result)
  );

  // The result fields come straight from the final stage's register.
  assign shade.shade_value = result.value;
  assign shade.saturated   = result.sat;

endmodule
